// ----- rtl/keypad_debounce_long_press_unit_defines.svh -----
// Assertion macros shared by the keypad debouncer RTL.
// Every macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef KEYPAD_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH
`define KEYPAD_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define KDLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("keypad debouncer: assertion failed");

`define KDLP_ASSERT_IMPL(lbl, cond, expct) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expct)) \
    else $error("keypad debouncer: implication failed");

`else

`define KDLP_ASSERT(lbl, prop)
`define KDLP_ASSERT_IMPL(lbl, cond, expct)

`endif

`endif

// ----- rtl/kdlp_pkg.sv -----
package kdlp_pkg;

  // Width of timestamps and of the two time thresholds.
  localparam int unsigned TimeW = 32;
  localparam int unsigned KeyW  = 8;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned CfgIdxW = 2;

  // The hold key, '#'.
  localparam logic [KeyW-1:0] HoldKey = 8'h23;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDebounce  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPress = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdleCode  = 2'd2;

  localparam logic [TimeW-1:0] DebounceReset  = 32'd20;
  localparam logic [TimeW-1:0] LongPressReset = 32'd1000;
  localparam logic [KeyW-1:0]  IdleReset      = 8'd0;

  typedef enum logic [1:0] {
    KindPress = 2'd0,
    KindShort = 2'd1,
    KindLong  = 2'd2
  } kind_e;

  // Debouncer state carried from one sample to the next.
  typedef struct packed {
    logic [KeyW-1:0]  cand_key;
    logic [KeyW-1:0]  stable_key;
    logic [TimeW-1:0] cand_since;
    logic [TimeW-1:0] hold_since;
    logic             long_given;
  } state_t;

  // One result word.
  typedef struct packed {
    logic            event_valid;
    logic [KeyW-1:0] event_key;
    kind_e           event_kind;
    logic            activity;
  } result_t;

  // Configuration as seen by the step logic.
  typedef struct packed {
    logic [TimeW-1:0] debounce_time;
    logic [TimeW-1:0] long_press_time;
    logic [KeyW-1:0]  idle_code;
  } cfg_t;

endpackage

// ----- rtl/kdlp_step.sv -----
module kdlp_step (
  input  kdlp_pkg::cfg_t                  cfg_i,
  input  kdlp_pkg::state_t                state_i,
  input  logic [kdlp_pkg::KeyW-1:0]       key_i,
  input  logic [kdlp_pkg::TimeW-1:0]      now_i,
  output kdlp_pkg::state_t                state_o,
  output kdlp_pkg::result_t               result_o
);

  logic [kdlp_pkg::TimeW-1:0] cand_elapsed;
  logic [kdlp_pkg::TimeW-1:0] hold_elapsed;

  // Differences wrap naturally at the time width.
  assign cand_elapsed = now_i - state_i.cand_since;
  assign hold_elapsed = now_i - state_i.hold_since;

  always_comb begin
    logic emit;
    logic done;
    state_o  = state_i;
    result_o = '{event_valid: 1'b0, event_key: '0,
                 event_kind: kdlp_pkg::KindPress, activity: 1'b0};
    emit = 1'b0;
    done = 1'b0;
    if (key_i != state_i.cand_key) begin
      // A new raw code restarts the debounce window.
      state_o.cand_key   = key_i;
      state_o.cand_since = now_i;
    end else if (cand_elapsed >= cfg_i.debounce_time) begin
      if (state_i.stable_key != state_i.cand_key) begin
        state_o.stable_key = state_i.cand_key;
        if (state_i.stable_key == kdlp_pkg::HoldKey) begin
          // Leaving the hold key always clears its tracking.
          emit = (state_i.cand_key == cfg_i.idle_code) && !state_i.long_given;
          state_o.long_given = 1'b0;
          state_o.hold_since = '0;
          if (emit) begin
            result_o.event_valid = 1'b1;
            result_o.event_key   = kdlp_pkg::HoldKey;
            result_o.event_kind  = kdlp_pkg::KindShort;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (state_i.cand_key == kdlp_pkg::HoldKey) begin
            result_o.activity  = 1'b1;
            state_o.hold_since = now_i;
            state_o.long_given = 1'b0;
          end else if (state_i.cand_key != cfg_i.idle_code) begin
            result_o.activity    = 1'b1;
            result_o.event_valid = 1'b1;
            result_o.event_key   = state_i.cand_key;
            result_o.event_kind  = kdlp_pkg::KindPress;
          end
        end
      end else if (state_i.stable_key == kdlp_pkg::HoldKey && !state_i.long_given &&
                   hold_elapsed >= cfg_i.long_press_time) begin
        state_o.long_given   = 1'b1;
        result_o.event_valid = 1'b1;
        result_o.event_key   = kdlp_pkg::HoldKey;
        result_o.event_kind  = kdlp_pkg::KindLong;
      end
    end
  end

endmodule

// ----- rtl/keypad_debounce_long_press_unit.sv -----
// Keypad debouncer with long-press detection for the hold key '#'.
// Input channel: in_valid_i/in_ready_o carry one keypad sample per word, a raw
// key code and a free-running millisecond timestamp. Output channel:
// out_valid_o/out_ready_i carry exactly one result word per sample, in order:
// an event flag, the event key and kind (press, short press, long press) and
// an activity flag for a newly accepted key.
// A sample is first captured in an input register; the step logic then
// updates the debouncer state and writes the result register, from which the
// receiver takes the result word. One sample can be taken in every cycle
// while the receiver keeps out_ready_i high.
// If the receiver stalls, the result register holds its word and the input
// register still takes one more sample; after that in_ready_o falls until the
// result word is taken.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i) and is
// meant to be written only while no samples are in flight. Writes to an index
// beyond the three registers are ignored.
// Reset (rst_ni, asynchronous, active low) empties both pipeline registers,
// restores the default thresholds (20 ms debounce, 1000 ms long press, idle
// code zero) and sets the candidate and stable keys to the idle code.
module keypad_debounce_long_press_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [kdlp_pkg::KeyW-1:0]       raw_key_i,
  input  logic [kdlp_pkg::TimeW-1:0]      now_time_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            event_valid_o,
  output logic [kdlp_pkg::KeyW-1:0]       event_key_o,
  output logic [1:0]                      event_kind_o,
  output logic                            activity_started_o,
  input  logic                            cfg_we_i,
  input  logic [kdlp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [kdlp_pkg::CfgW-1:0]       cfg_data_i
);

`include "keypad_debounce_long_press_unit_defines.svh"

  kdlp_pkg::cfg_t    cfg_q;
  kdlp_pkg::state_t  state_q, state_d;
  kdlp_pkg::result_t result_d, result_q;

  logic                       s1_valid_q;
  logic [kdlp_pkg::KeyW-1:0]  s1_key_q;
  logic [kdlp_pkg::TimeW-1:0] s1_time_q;
  logic                       out_valid_q;
  logic                       advance;
  logic                       in_fire;

  // The result register can take a new word when it is empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= kdlp_pkg::DebounceReset;
      cfg_q.long_press_time <= kdlp_pkg::LongPressReset;
      cfg_q.idle_code       <= kdlp_pkg::IdleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kdlp_pkg::CfgDebounce:  cfg_q.debounce_time   <= cfg_data_i[kdlp_pkg::TimeW-1:0];
        kdlp_pkg::CfgLongPress: cfg_q.long_press_time <= cfg_data_i[kdlp_pkg::TimeW-1:0];
        kdlp_pkg::CfgIdleCode:  cfg_q.idle_code       <= cfg_data_i[kdlp_pkg::KeyW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: control bit with reset, payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_key_q  <= raw_key_i;
      s1_time_q <= now_time_i;
    end
  end

  kdlp_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .key_i    (s1_key_q),
    .now_i    (s1_time_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // The debouncer state moves on exactly when a sample enters the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cand_key   <= kdlp_pkg::IdleReset;
      state_q.stable_key <= kdlp_pkg::IdleReset;
      state_q.cand_since <= '0;
      state_q.hold_since <= '0;
      state_q.long_given <= 1'b0;
      out_valid_q        <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign event_valid_o      = result_q.event_valid;
  assign event_key_o        = result_q.event_key;
  assign event_kind_o       = 2'(result_q.event_kind);
  assign activity_started_o = result_q.activity;

  // The long-press flag is only ever set while the hold key is the stable key.
  `KDLP_ASSERT_IMPL(a_long_needs_hold, state_q.long_given,
                    state_q.stable_key == kdlp_pkg::HoldKey)
  // The hold start time is cleared whenever the hold key is not stable.
  `KDLP_ASSERT_IMPL(a_hold_time_cleared, state_q.stable_key != kdlp_pkg::HoldKey,
                    state_q.hold_since == '0)
  // Short and long press events always refer to the hold key.
  `KDLP_ASSERT_IMPL(a_hold_events_key,
                    out_valid_q && result_q.event_valid &&
                    result_q.event_kind != kdlp_pkg::KindPress,
                    result_q.event_key == kdlp_pkg::HoldKey)
  // A word without an event carries zero key and kind.
  `KDLP_ASSERT_IMPL(a_no_event_zero, out_valid_q && !result_q.event_valid,
                    result_q.event_key == '0 && result_q.event_kind == kdlp_pkg::KindPress)
  // The state only changes when a sample is moved into the result register.
  `KDLP_ASSERT(a_state_moves_with_word,
               !(advance && s1_valid_q) |=> $stable(state_q))

endmodule
